FILE: rtl/core/mbrx_pkg.sv
// Shared types and constants of the Modbus encoder response receiver.
`default_nettype none
package mbrx_pkg;

	// Frame layout: five bytes under the CRC, then the CRC low and high bytes.
	localparam int unsigned FRAME_LEN = 7;
	localparam int unsigned CRC_SPAN  = 5;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Result status codes.
	typedef logic [1:0] status_t;
	localparam status_t STATUS_OK      = 2'd0;
	localparam status_t STATUS_CRC_ERR = 2'd1;
	localparam status_t STATUS_HDR_ERR = 2'd2;

	// Configuration register indexes.
	typedef logic [1:0] cfg_index_t;
	localparam cfg_index_t CFG_SLAVE_ID      = 2'd0;
	localparam cfg_index_t CFG_FUNCTION_CODE = 2'd1;
	localparam cfg_index_t CFG_TIMEOUT_TICKS = 2'd2;

	// Register values after reset.
	localparam logic [7:0] SLAVE_ID_RST      = 8'h01;
	localparam logic [7:0] FUNCTION_CODE_RST = 8'h03;
	localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd10;

	// Input item kinds.
	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

endpackage
`default_nettype wire

FILE: rtl/core/modbus_encoder_response_receiver_unit.sv
// Top level of the Modbus RTU encoder response receiver with CRC-16 check.
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   ----------------------------------------------
//  input     byte_valid / byte_stall   func, rx_data
//  result    result_valid / result_stall  status, angle_value, frame_crc, computed_crc
//  config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Each beat passes an input register and then the result register: the result
// of a frame is registered as its seventh byte leaves the input register, and one
// beat can be accepted in every cycle while byte_stall is low. The frame state is
// updated as a beat leaves the input register. A stalled result only holds back
// the input when the waiting beat would itself produce a result. Reset clears the
// control state and loads the configuration defaults; cfg_ready is always high.
`default_nettype none
module modbus_encoder_response_receiver_unit (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Input beats
	input  wire logic                  byte_valid,
	output logic                       byte_stall,
	input  wire logic                  func,
	input  wire logic [7:0]            rx_data,
	// Result beats
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output mbrx_pkg::status_t          status,
	output logic      [15:0]           angle_value,
	output logic      [15:0]           frame_crc,
	output logic      [15:0]           computed_crc,
	// Configuration writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire mbrx_pkg::cfg_index_t  cfg_index,
	input  wire logic [7:0]            cfg_data
);
	import mbrx_pkg::*;

	localparam int unsigned STORE_LEN = FRAME_LEN - 1;
	localparam logic [2:0]  LAST_IDX  = 3'(FRAME_LEN - 1);
	localparam logic [2:0]  SPAN_IDX  = 3'(CRC_SPAN);

	// Configuration registers
	logic [7:0] slave_id_q;
	logic [7:0] function_code_q;
	logic [7:0] timeout_ticks_q;

	// Frame state
	logic [2:0]  byte_index_q;
	logic [15:0] running_crc_q;
	logic [7:0]  timeout_count_q;
	logic [7:0]  frame_q [STORE_LEN];

	// Input register
	logic       item_valid_s1;
	logic       func_s1;
	logic [7:0] data_s1;

	// Result register
	logic        result_valid_q;
	status_t     status_q;
	logic [15:0] angle_q;
	logic [15:0] frame_crc_q;
	logic [15:0] computed_crc_q;

	logic        s1_result;
	logic        s1_go;
	logic        out_free;
	logic        in_accept;
	logic [15:0] crc_base;
	logic [15:0] crc_next;
	logic [15:0] rx_crc;
	status_t     status_d;
	logic [15:0] angle_d;

	assign cfg_ready = 1'b1;

	// Configuration writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_id_q      <= SLAVE_ID_RST;
			function_code_q <= FUNCTION_CODE_RST;
			timeout_ticks_q <= TIMEOUT_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SLAVE_ID:      slave_id_q      <= cfg_data;
				CFG_FUNCTION_CODE: function_code_q <= cfg_data;
				CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data;
				default:           ;
			endcase
		end
	end

	// Flow control between input register and result register.
	assign s1_result  = item_valid_s1 && (func_s1 == FUNC_BYTE) && (byte_index_q == LAST_IDX);
	assign out_free   = !result_valid_q || !result_stall;
	assign s1_go      = item_valid_s1 && (!s1_result || out_free);
	assign byte_stall = item_valid_s1 && !s1_go;
	assign in_accept  = byte_valid && !byte_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_valid_s1 || s1_go) begin
			item_valid_s1 <= in_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			func_s1 <= func;
			data_s1 <= rx_data;
		end
	end

	// The CRC restarts from its initial value on the first byte of a frame.
	assign crc_base = (byte_index_q == 3'd0) ? CRC_INIT : running_crc_q;

	mbrx_crc16 u_crc (
		.crc_in  (crc_base),
		.data    (data_s1),
		.crc_out (crc_next)
	);

	// Frame checks on the last byte; the CRC check takes precedence.
	assign rx_crc = {data_s1, frame_q[STORE_LEN - 1]};

	always_comb begin
		angle_d = 16'h0000;
		if (rx_crc != running_crc_q) begin
			status_d = STATUS_CRC_ERR;
		end else if (frame_q[0] != slave_id_q || frame_q[1] != function_code_q) begin
			status_d = STATUS_HDR_ERR;
		end else begin
			status_d = STATUS_OK;
			angle_d  = {frame_q[3], frame_q[4]};
		end
	end

	// Frame state update as a beat leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q    <= 3'd0;
			running_crc_q   <= CRC_INIT;
			timeout_count_q <= 8'd0;
		end else if (s1_go) begin
			if (func_s1 == FUNC_TICK) begin
				if (timeout_count_q != 8'd0) begin
					timeout_count_q <= timeout_count_q - 8'd1;
					if (timeout_count_q == 8'd1) begin
						byte_index_q <= 3'd0;
					end
				end
			end else if (byte_index_q == LAST_IDX) begin
				byte_index_q    <= 3'd0;
				timeout_count_q <= 8'd0;
			end else begin
				byte_index_q <= byte_index_q + 3'd1;
				if (byte_index_q == 3'd0) begin
					timeout_count_q <= timeout_ticks_q;
					running_crc_q   <= CRC_INIT;
				end
				if (byte_index_q < SPAN_IDX) begin
					running_crc_q <= crc_next;
				end
			end
		end
	end

	// Stored frame bytes; the last byte is used straight from the input register.
	always_ff @(posedge clk) begin
		if (s1_go && (func_s1 == FUNC_BYTE) && (byte_index_q != LAST_IDX)) begin
			frame_q[byte_index_q] <= data_s1;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s1_go && s1_result) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_result) begin
			status_q       <= status_d;
			angle_q        <= angle_d;
			frame_crc_q    <= rx_crc;
			computed_crc_q <= running_crc_q;
		end
	end

	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign angle_value  = angle_q;
	assign frame_crc    = frame_crc_q;
	assign computed_crc = computed_crc_q;

endmodule
`default_nettype wire

FILE: rtl/core/mbrx_crc16.sv
// Modbus CRC-16 update by one byte, bit-reflected polynomial 0xA001.
`default_nettype none
module mbrx_crc16 (
	input  wire logic [15:0] crc_in,
	input  wire logic [7:0]  data,
	output logic      [15:0] crc_out
);
	import mbrx_pkg::*;

	// Eight shift steps of the reflected CRC, each a shift and a conditional XOR.
	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule
`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench of the Modbus RTU encoder response receiver.
`timescale 1ns / 100ps
import mbrx_pkg::*;

// One decoded response as it leaves the result channel.
typedef struct packed {
	status_t     status;
	logic [15:0] angle_value;
	logic [15:0] frame_crc;
	logic [15:0] computed_crc;
} frame_result_t;

// Register index that decodes to no register.
localparam cfg_index_t CFG_UNUSED = 2'd3;

// Folds one byte into the Modbus CRC-16.
function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
	logic [15:0] c;
	c = crc ^ {8'h00, b};
	for (int k = 0; k < 8; k++) begin
		c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
	end
	return c;
endfunction

// Tracks the frame state of the receiver and holds the responses still due.
class frame_scoreboard;
	logic [7:0]    slave_id;
	logic [7:0]    function_code;
	logic [7:0]    timeout_ticks;
	logic [2:0]    byte_pos;
	logic [7:0]    frame [7];
	logic [15:0]   crc_acc;
	logic [7:0]    ticks_left;
	frame_result_t awaited [$];
	int unsigned   errors;

	function new();
		slave_id      = SLAVE_ID_RST;
		function_code = FUNCTION_CODE_RST;
		timeout_ticks = TIMEOUT_TICKS_RST;
		byte_pos      = 3'd0;
		crc_acc       = CRC_INIT;
		ticks_left    = 8'd0;
		errors        = 0;
		foreach (frame[i]) frame[i] = 8'h00;
	endfunction

	function void note_config(input cfg_index_t idx, input logic [7:0] data);
		case (idx)
			CFG_SLAVE_ID: begin
				slave_id = data;
			end
			CFG_FUNCTION_CODE: begin
				function_code = data;
			end
			CFG_TIMEOUT_TICKS: begin
				timeout_ticks = data;
			end
			default: begin
			end
		endcase
	endfunction

	// Advances the frame state by one accepted input beat.
	function void note_beat(input logic kind, input logic [7:0] data);
		frame_result_t res;
		if (kind == FUNC_TICK) begin
			// A tick only counts down a running timeout; reaching zero drops the frame.
			if (ticks_left != 8'd0) begin
				ticks_left--;
				if (ticks_left == 8'd0) byte_pos = 3'd0;
			end
		end else begin
			if (byte_pos >= FRAME_LEN) byte_pos = 3'd0;
			if (byte_pos == 3'd0) begin
				ticks_left = timeout_ticks;
				crc_acc    = CRC_INIT;
			end
			frame[byte_pos] = data;
			if (byte_pos < CRC_SPAN) crc_acc = crc16_update(crc_acc, data);
			byte_pos++;
			// The seventh byte closes the frame and yields one response.
			if (byte_pos == FRAME_LEN) begin
				ticks_left           = 8'd0;
				byte_pos             = 3'd0;
				res.frame_crc        = {frame[6], frame[5]};
				res.computed_crc     = crc_acc;
				res.angle_value      = 16'h0000;
				if (res.frame_crc != res.computed_crc) begin
					res.status = STATUS_CRC_ERR;
				end else if (frame[0] != slave_id || frame[1] != function_code) begin
					res.status = STATUS_HDR_ERR;
				end else begin
					res.status      = STATUS_OK;
					res.angle_value = {frame[3], frame[4]};
				end
				awaited.push_back(res);
			end
		end
	endfunction

	// Compares one accepted response with the oldest one due.
	function void check_frame(input frame_result_t got);
		frame_result_t exp;
		if (awaited.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("%0t: unexpected response status %0d angle %h rx_crc %h calc_crc %h",
					$time, got.status, got.angle_value, got.frame_crc, got.computed_crc);
		end else begin
			exp = awaited.pop_front();
			if (got.status !== exp.status || got.angle_value !== exp.angle_value ||
			    got.frame_crc !== exp.frame_crc ||
			    got.computed_crc !== exp.computed_crc) begin
				errors++;
				if (errors <= 10)
					$display({"%0t: mismatch: expected status %0d angle %h rx_crc %h ",
						"calc_crc %h, got status %0d angle %h rx_crc %h calc_crc %h"},
						$time, exp.status, exp.angle_value, exp.frame_crc,
						exp.computed_crc, got.status, got.angle_value,
						got.frame_crc, got.computed_crc);
			end
		end
	endfunction

	function void close();
		if (awaited.size() != 0) begin
			errors += awaited.size();
			$display("%0d responses never arrived", awaited.size());
		end
	endfunction
endclass

module testbench;

	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE      = 8;

	logic       clk;
	logic       arst_n;
	logic       byte_valid;
	logic       byte_stall;
	logic       func;
	logic [7:0] rx_data;
	logic       result_valid;
	logic       result_stall;
	status_t    status;
	logic [15:0] angle_value;
	logic [15:0] frame_crc;
	logic [15:0] computed_crc;
	logic       cfg_valid;
	logic       cfg_ready;
	cfg_index_t cfg_index;
	logic [7:0] cfg_data;

	frame_scoreboard sb;
	bit              calm;
	int              beats_sent;
	int              quiet_cycles;

	modbus_encoder_response_receiver_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.func         (func),
		.rx_data      (rx_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.angle_value  (angle_value),
		.frame_crc    (frame_crc),
		.computed_crc (computed_crc),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Clock with a 12 ns period.
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// The result side stalls now and then, except in calm stretches.
	always @(posedge clk) begin
		result_stall <= !calm && ($urandom_range(99) < 11);
	end

	// Every accepted response is checked against the oldest one due.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_frame({status, angle_value, frame_crc, computed_crc});
	end

	// Watchdog: ends the run when no beat moves on any channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && !byte_stall) || (result_valid && !result_stall) ||
			    (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no beat accepted for %0d cycles", quiet_cycles);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Sends one input beat, with an occasional idle gap before it.
	task automatic send_beat(input logic kind, input logic [7:0] data);
		if (!calm && $urandom_range(99) < 11) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		func       <= kind;
		rx_data    <= data;
		do @(posedge clk); while (byte_stall);
		sb.note_beat(kind, data);
		beats_sent++;
	endtask

	// Sends a full seven-byte response, optionally with a corrupted bit and ticks between bytes.
	task automatic send_frame(input logic [7:0] id, input logic [7:0] fc, input logic [7:0] hi,
			input logic [7:0] lo, input bit crc_ok, input int tick_pct);
		logic [7:0]  b [7];
		logic [15:0] crc;
		int          ticks;
		b[0] = id;
		b[1] = fc;
		b[2] = 8'h02;
		b[3] = hi;
		b[4] = lo;
		if (tick_pct != 0) b[2] = 8'($urandom);
		crc = CRC_INIT;
		for (int i = 0; i < 5; i++) crc = crc16_update(crc, b[i]);
		b[5] = crc[7:0];
		b[6] = crc[15:8];
		// A single flipped bit anywhere in the frame always breaks the CRC.
		if (!crc_ok) b[$urandom_range(6)] ^= 8'h01 << $urandom_range(7);
		ticks = 0;
		for (int i = 0; i < 7; i++) begin
			if (i != 0 && $urandom_range(99) < tick_pct &&
			    (sb.timeout_ticks == 8'd0 || ticks + 1 < sb.timeout_ticks)) begin
				send_beat(FUNC_TICK, 8'($urandom));
				ticks++;
			end
			send_beat(FUNC_BYTE, b[i]);
		end
	endtask

	// Starts a frame and lets it run out of time, with up to two extra ticks after; a zero timeout keeps the frame.
	task automatic send_dropped_frame();
		int n;
		int t;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++)
			send_beat(FUNC_BYTE, (i == 0) ? sb.slave_id : 8'($urandom));
		t = (sb.timeout_ticks == 8'd0) ? $urandom_range(1, 5) : sb.timeout_ticks;
		repeat (t + $urandom_range(0, 2)) send_beat(FUNC_TICK, 8'($urandom));
	endtask

	// One random sequence: mostly well-formed frames, some broken ones and noise.
	task automatic run_sequence();
		int         r;
		logic [7:0] id;
		logic [7:0] fc;
		// Complete any partial frame first so that the next frame is aligned.
		while (sb.byte_pos != 3'd0) send_beat(FUNC_BYTE, 8'($urandom));
		r = $urandom_range(99);
		if (r < 55) begin
			send_frame(sb.slave_id, sb.function_code, 8'($urandom), 8'($urandom), 1'b1, 10);
		end else if (r < 70) begin
			id = $urandom_range(1) ? sb.slave_id : 8'($urandom);
			fc = $urandom_range(1) ? sb.function_code : 8'($urandom);
			if (id == sb.slave_id && fc == sb.function_code) id ^= 8'h80;
			send_frame(id, fc, 8'($urandom), 8'($urandom), 1'b1, 10);
		end else if (r < 80) begin
			send_frame(sb.slave_id, sb.function_code, 8'($urandom), 8'($urandom), 1'b0, 10);
		end else if (r < 90 && (sb.timeout_ticks <= 8'd16 || $urandom_range(7) == 0)) begin
			send_dropped_frame();
		end else begin
			repeat ($urandom_range(1, 6)) send_beat(1'($urandom_range(1)), 8'($urandom));
		end
	endtask

	// Waits until every response has arrived and the pipeline has emptied.
	task automatic wait_idle();
		byte_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.note_config(idx, data);
	endtask

	// Writes a full register setting while the block is idle.
	task automatic configure(input logic [7:0] id, input logic [7:0] fc, input logic [7:0] tmo,
			input bit junk);
		wait_idle();
		write_reg(CFG_SLAVE_ID, id);
		write_reg(CFG_FUNCTION_CODE, fc);
		write_reg(CFG_TIMEOUT_TICKS, tmo);
		if (junk) write_reg(CFG_UNUSED, 8'($urandom));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int phase_end;
		sb           = new();
		calm         = 1'b0;
		beats_sent   = 0;
		quiet_cycles = 0;
		arst_n       = 1'b0;
		byte_valid   = 1'b0;
		func         = FUNC_BYTE;
		rx_data      = 8'h00;
		result_stall = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_SLAVE_ID;
		cfg_data     = 8'h00;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset setting: idle tick, top angle, bad CRC, bad header.
		send_beat(FUNC_TICK, 8'hFF);
		send_frame(SLAVE_ID_RST, FUNCTION_CODE_RST, 8'hFF, 8'hFF, 1'b1, 0);
		send_frame(SLAVE_ID_RST, FUNCTION_CODE_RST, 8'h00, 8'h00, 1'b0, 0);
		send_frame(SLAVE_ID_RST, 8'hFF, 8'h12, 8'h34, 1'b1, 0);

		// Random part over several settings, the extremes and a zero timeout among them.
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: configure(8'h00, 8'h00, 8'd1, 1'b1);
				1: configure(8'hFF, 8'hFF, 8'd255, 1'b0);
				2: configure(8'h01, 8'h03, 8'd0, 1'b1);
				default: configure(8'($urandom), 8'($urandom), 8'(($urandom_range(3) == 0) ?
					$urandom_range(1, 255) : $urandom_range(1, 20)),
					1'($urandom_range(1)));
			endcase
			calm      = (p == 2);
			phase_end = beats_sent + 72;
			while (beats_sent < phase_end) run_sequence();
		end

		wait_idle();
		sb.close();
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/mbrx_pkg.sv
rtl/core/mbrx_crc16.sv
rtl/core/modbus_encoder_response_receiver_unit.sv
test/testbench.sv
